@@ hw/rtl/lzw_variable_width_decoder_unit_defines.svh @@
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef LZW_VARIABLE_WIDTH_DECODER_UNIT_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LZW_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lzw decoder check failed");
`define LZW_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lzw decoder check failed");
`else
`define LZW_ASSERT(name, prop)
`define LZW_ASSERT_IMPL(name, pre, post)
`endif

`endif

@@ hw/rtl/lzw_vwd_pkg.sv @@
package lzw_vwd_pkg;

  localparam logic [12:0] CODE_RESET  = 13'h100;
  localparam logic [12:0] CODE_END    = 13'h101;
  localparam logic [13:0] FIRST_ENTRY = 14'h102;
  localparam logic [13:0] ENTRY_LIMIT = 14'h2000;
  localparam logic [16:0] LEN_MAX     = 17'h1FFFF;
  localparam logic [3:0]  WIDTH_MIN   = 4'd9;
  localparam logic [3:0]  WIDTH_MAX   = 4'd13;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_WAITING   = 3'd1;
  localparam logic [2:0] ST_COMPLETE  = 3'd2;
  localparam logic [2:0] ST_END_CODE  = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic [15:0] offset;
    logic [16:0] length;
  } entry_t;

  typedef struct packed {
    logic        re;
    logic [12:0] raddr;
    logic        we;
    logic [12:0] waddr;
    entry_t      wdata;
  } dict_req_t;

  typedef struct packed {
    logic        re;
    logic [15:0] raddr;
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
  } hist_req_t;

endpackage

@@ hw/rtl/lzw_variable_width_decoder_unit.sv @@
// LZW decoder for LSB-first packed codes of 9 to 13 bits. An input item with
// tuser 0 feeds one compressed byte (tlast marks the final one) into a 32-bit
// bit buffer and answers. An item with tuser 1 pulls at most one output byte:
// a copied byte takes a history read, then a write back; a literal takes a
// decode step; each reset or unknown code on the way adds a decode step and a
// dictionary code adds a dictionary read. The user sets the output length
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// The history reads as zero where not yet written, tracked by a fill count, so
// there is no clearing pass after reset. A new item is taken once the previous
// result is in the output register and that register is free or being taken.
module lzw_variable_width_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,   // output_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tlast,  // in_last
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // accepted, out_valid, out_byte[7:0], zero pad
  output logic        m_axis_tlast,  // out_last
  output logic [2:0]  m_axis_tuser   // status
);
  import lzw_vwd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_COPY   = 2'd1;
  localparam logic [1:0] S_DECODE = 2'd2;
  localparam logic [1:0] S_DICT   = 2'd3;

  logic [1:0]  state, state_next;
  logic [31:0] bb, bb_next;
  logic [5:0]  bc, bc_next;
  logic [3:0]  cw, cw_next;
  logic [13:0] ne, ne_next;
  logic [16:0] wp, wp_next;
  logic [15:0] cs, cs_next;
  logic [16:0] cr, cr_next;
  logic        ended, ended_next;
  logic [2:0]  fin, fin_next;
  logic [16:0] olen;

  logic        ov, o_acc, o_val, o_last;
  logic [7:0]  o_byte;
  logic [2:0]  o_status;

  logic        produce, r_acc, r_val, r_last;
  logic [7:0]  r_byte;
  logic [2:0]  r_status;

  logic        pb_en, ae_en;
  logic [7:0]  pb_byte;
  logic [16:0] ae_len, pb_pos;
  logic [13:0] maskw, ne_add;
  logic [12:0] code;
  logic        have;
  logic        acc_in;

  dict_req_t dreq;
  hist_req_t hreq;
  entry_t    dq;
  logic [7:0] hq;

  lzw_vwd_dict u_dict (.clk(clk), .req(dreq), .rdata(dq));
  lzw_vwd_hist u_hist (.clk(clk), .rst(rst), .req(hreq), .rdata(hq));

  assign s_axis_tready = (state == S_IDLE) && (!ov || m_axis_tready);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign maskw         = (14'd1 << cw) - 14'd1;

  always_comb begin
    state_next = state;
    bb_next    = bb;
    bc_next    = bc;
    cw_next    = cw;
    ne_next    = ne;
    wp_next    = wp;
    cs_next    = cs;
    cr_next    = cr;
    ended_next = ended;
    fin_next   = fin;
    produce    = 1'b0;
    r_acc      = 1'b0;
    r_val      = 1'b0;
    r_last     = 1'b0;
    r_byte     = 8'd0;
    r_status   = fin;
    pb_en      = 1'b0;
    pb_byte    = 8'd0;
    ae_en      = 1'b0;
    ae_len     = 17'd0;
    code       = 13'd0;
    have       = 1'b0;
    ne_add     = ne;
    pb_pos     = wp + 17'd1;
    dreq       = '0;
    hreq       = '0;

    case (state)
      S_IDLE: begin
        if (acc_in) begin
          if (!s_axis_tuser) begin
            produce = 1'b1;
            if (!ended && bc <= 6'd24) begin
              bb_next    = bb | ({24'd0, s_axis_tdata} << bc[4:0]);
              bc_next    = bc + 6'd8;
              ended_next = s_axis_tlast;
              r_acc      = 1'b1;
            end
          end else if (fin != ST_RUNNING) begin
            produce = 1'b1;
          end else if (wp >= olen) begin
            fin_next = ST_COMPLETE;
            r_status = ST_COMPLETE;
            produce  = 1'b1;
          end else if (cr != 17'd0) begin
            hreq.re    = 1'b1;
            hreq.raddr = cs;
            state_next = S_COPY;
          end else begin
            state_next = S_DECODE;
          end
        end
      end
      S_COPY: begin
        pb_en      = 1'b1;
        pb_byte    = hq;
        cs_next    = cs + 16'd1;
        cr_next    = cr - 17'd1;
        state_next = S_IDLE;
      end
      S_DECODE: begin
        if (bc < {2'b00, cw}) begin
          if (!ended) begin
            r_status   = ST_WAITING;
            produce    = 1'b1;
            state_next = S_IDLE;
          end else if (bc == 6'd0) begin
            fin_next   = ST_EXHAUSTED;
            r_status   = ST_EXHAUSTED;
            produce    = 1'b1;
            state_next = S_IDLE;
          end else begin
            // partial final code, zeros above the remaining bits
            code    = bb[12:0] & maskw[12:0];
            bb_next = '0;
            bc_next = '0;
            have    = 1'b1;
          end
        end else begin
          code    = bb[12:0] & maskw[12:0];
          bb_next = bb >> cw;
          bc_next = bc - {2'b00, cw};
          have    = 1'b1;
        end
        if (have) begin
          if (code == CODE_RESET) begin
            cw_next = WIDTH_MIN;
            ne_next = FIRST_ENTRY;
          end else if (code == CODE_END) begin
            fin_next   = ST_END_CODE;
            r_status   = ST_END_CODE;
            produce    = 1'b1;
            state_next = S_IDLE;
          end else if (code <= 13'h0FF) begin
            pb_en      = 1'b1;
            pb_byte    = code[7:0];
            ae_en      = 1'b1;
            ae_len     = 17'd1;
            state_next = S_IDLE;
          end else if ({1'b0, code} >= FIRST_ENTRY && {1'b0, code} < ne) begin
            dreq.re    = 1'b1;
            dreq.raddr = code;
            state_next = S_DICT;
          end else begin
            // unknown code: entry of length one, keep decoding
            ae_en  = 1'b1;
            ae_len = 17'd0;
          end
        end
      end
      S_DICT: begin
        cs_next = dq.offset;
        cr_next = dq.length;
        ae_en   = 1'b1;
        ae_len  = dq.length;
        if (dq.length != 17'd0) begin
          hreq.re    = 1'b1;
          hreq.raddr = dq.offset;
          state_next = S_COPY;
        end else begin
          state_next = S_DECODE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (ae_en) begin
      if (ne < ENTRY_LIMIT) begin
        dreq.we            = 1'b1;
        dreq.waddr         = ne[12:0];
        dreq.wdata.offset  = wp[15:0];
        dreq.wdata.length  = (ae_len == LEN_MAX) ? LEN_MAX : ae_len + 17'd1;
        ne_add             = ne + 14'd1;
      end
      ne_next = ne_add;
      if ((ne_add - 14'd1) > maskw && cw < WIDTH_MAX) begin
        cw_next = cw + 4'd1;
      end
    end

    if (pb_en) begin
      hreq.we    = 1'b1;
      hreq.waddr = wp[15:0];
      hreq.wdata = pb_byte;
      wp_next    = pb_pos;
      r_val      = 1'b1;
      r_byte     = pb_byte;
      produce    = 1'b1;
      if (pb_pos >= olen) begin
        fin_next = ST_COMPLETE;
        r_last   = 1'b1;
        r_status = ST_COMPLETE;
      end else begin
        r_status = ST_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bb    <= '0;
      bc    <= '0;
      cw    <= WIDTH_MIN;
      ne    <= FIRST_ENTRY;
      wp    <= '0;
      cs    <= '0;
      cr    <= '0;
      ended <= 1'b0;
      fin   <= ST_RUNNING;
      olen  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      bb    <= bb_next;
      bc    <= bc_next;
      cw    <= cw_next;
      ne    <= ne_next;
      wp    <= wp_next;
      cs    <= cs_next;
      cr    <= cr_next;
      ended <= ended_next;
      fin   <= fin_next;
      if (cfg_wr_en) begin
        olen <= cfg_wr_data;
      end
      if (produce) begin
        ov <= 1'b1;
      end else if (m_axis_tready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      o_acc    <= r_acc;
      o_val    <= r_val;
      o_byte   <= r_byte;
      o_last   <= r_last;
      o_status <= r_status;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {6'd0, o_byte, o_val, o_acc};
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_status;

  `include "lzw_variable_width_decoder_unit_defines.svh"

  // a result must never land on one that is still waiting
  `LZW_ASSERT(a_no_overrun, !(produce && ov && !m_axis_tready))
  `LZW_ASSERT(a_width_range, cw >= WIDTH_MIN && cw <= WIDTH_MAX)
  `LZW_ASSERT(a_bits_fit, bc <= 6'd32)
  // a copy step always follows a history read issued the cycle before
  `LZW_ASSERT_IMPL(a_copy_after_read, state == S_COPY, $past(hreq.re))

endmodule

@@ hw/rtl/lzw_vwd_dict.sv @@
module lzw_vwd_dict (
  input  logic                  clk,
  input  lzw_vwd_pkg::dict_req_t req,
  output lzw_vwd_pkg::entry_t    rdata
);
  import lzw_vwd_pkg::*;

  entry_t mem [8192];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hw/rtl/lzw_vwd_hist.sv @@
module lzw_vwd_hist (
  input  logic                  clk,
  input  logic                  rst,
  input  lzw_vwd_pkg::hist_req_t req,
  output logic [7:0]            rdata
);
  import lzw_vwd_pkg::*;

  logic [7:0]  mem [65536];
  logic [7:0]  q;
  logic        q_ok;
  // bytes written since reset; writes go strictly in order from address zero
  logic [16:0] filled;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q    <= mem[req.raddr];
      q_ok <= filled[16] || ({1'b0, req.raddr} < filled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (req.we && !filled[16]) begin
      filled <= filled + 17'd1;
    end
  end

  // never-written bytes read as the reset value of zero
  assign rdata = q_ok ? q : 8'd0;

endmodule

@@ bench/tb_lzw_variable_width_decoder_unit.sv @@
`timescale 1ns / 100ps

module tb_lzw_variable_width_decoder_unit;
  import lzw_vwd_pkg::*;

  localparam logic MODE_FEED = 1'b0;
  localparam logic MODE_PULL = 1'b1;
  localparam int   ITEM_GOAL = 1700;
  localparam int   HANG_LIMIT = 20000;

  typedef struct packed {
    logic       acc;
    logic       ov;
    logic [7:0] b;
    logic       last;
    logic [2:0] st;
  } dec_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  lzw_variable_width_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // decoder mirror
  logic [31:0] bbuf;
  int          bcnt, cw, ne;
  logic [16:0] wpos, crem, olen;
  logic [15:0] csrc;
  bit          ended;
  logic [2:0]  fin;
  logic [15:0] ent_off [8192];
  logic [16:0] ent_len [8192];
  logic [7:0]  hist [65536];

  // stream encoder state
  longint      enc_acc;
  int          enc_bits, enc_cw, enc_ne;
  logic [7:0]  pend [$];

  dec_res_t    pending_results [$];
  int          errors = 0;
  int          n_items = 0;
  bit          calm = 1'b0;
  bit          moved;
  int          idle_cycles = 0;
  int          rx_stall = 0;

  function automatic void emit_byte(logic [7:0] b, inout dec_res_t r);
    hist[wpos[15:0]] = b;
    wpos = wpos + 17'd1;
    r.ov = 1'b1;
    r.b = b;
    if (wpos >= olen) begin
      fin = ST_COMPLETE;
      r.last = 1'b1;
      r.st = ST_COMPLETE;
    end else begin
      r.last = 1'b0;
      r.st = ST_RUNNING;
    end
  endfunction

  function automatic void copy_byte(inout dec_res_t r);
    logic [7:0] b;
    b = hist[csrc];
    csrc = csrc + 16'd1;
    crem = crem - 17'd1;
    emit_byte(b, r);
  endfunction

  function automatic void grow_dict(logic [16:0] start, int produced);
    int n;
    if (ne < ENTRY_LIMIT) begin
      n = produced + 1;
      if (n > LEN_MAX) n = LEN_MAX;
      ent_off[ne] = start[15:0];
      ent_len[ne] = n[16:0];
      ne++;
    end
    if (ne - 1 > (1 << cw) - 1 && cw < WIDTH_MAX) cw++;
  endfunction

  function automatic dec_res_t decode_item(logic mode, logic [7:0] din, logic dlast);
    dec_res_t r;
    int code, n;
    r = '0;
    r.st = fin;
    if (mode == MODE_FEED) begin
      if (!ended && bcnt <= 24) begin
        bbuf = bbuf | (32'(din) << bcnt);
        bcnt += 8;
        if (dlast) ended = 1'b1;
        r.acc = 1'b1;
      end
      return r;
    end
    if (fin != ST_RUNNING) return r;
    if (wpos >= olen) begin
      fin = ST_COMPLETE;
      r.st = ST_COMPLETE;
      return r;
    end
    if (crem > 0) begin
      copy_byte(r);
      return r;
    end
    while (1) begin
      if (bcnt < cw) begin
        if (!ended) begin
          r.st = ST_WAITING;
          return r;
        end
        if (bcnt == 0) begin
          fin = ST_EXHAUSTED;
          r.st = ST_EXHAUSTED;
          return r;
        end
        // partial code at the tail reads zeros above the remaining bits
        code = bbuf & ((1 << cw) - 1);
        bbuf = 0;
        bcnt = 0;
      end else begin
        code = bbuf & ((1 << cw) - 1);
        bbuf = bbuf >> cw;
        bcnt -= cw;
      end
      if (code == CODE_RESET) begin
        cw = WIDTH_MIN;
        ne = FIRST_ENTRY;
        continue;
      end
      if (code == CODE_END) begin
        fin = ST_END_CODE;
        r.st = ST_END_CODE;
        return r;
      end
      if (code <= 255) begin
        n = wpos;
        emit_byte(code[7:0], r);
        grow_dict(n[16:0], 1);
        return r;
      end
      if (code >= FIRST_ENTRY && code < ne) begin
        n = ent_len[code];
        csrc = ent_off[code];
        crem = n[16:0];
        grow_dict(wpos, n);
        if (crem > 0) begin
          copy_byte(r);
          return r;
        end
        continue;
      end
      // unknown code still takes a dictionary slot
      grow_dict(wpos, 0);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom % 100;
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tvalid stays high after the accepting edge; the next item drops it only for a gap, wait_idle takes it down
  task automatic send_item(input logic mode, input logic [7:0] din, input logic dlast,
                           output logic took);
    dec_res_t r;
    int gap;
    r = decode_item(mode, din, dlast);
    pending_results.push_back(r);
    took = r.acc;
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= din;
    s_axis_tlast <= dlast;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic pull_once();
    logic took;
    send_item(MODE_PULL, 8'($urandom), 1'($urandom), took);
  endtask

  task automatic push_code(int code);
    enc_acc = enc_acc | (longint'(code) << enc_bits);
    enc_bits += enc_cw;
    while (enc_bits >= 8) begin
      pend.push_back(enc_acc[7:0]);
      enc_acc = enc_acc >> 8;
      enc_bits -= 8;
    end
    if (code == CODE_RESET) begin
      enc_cw = WIDTH_MIN;
      enc_ne = FIRST_ENTRY;
    end else if (code != CODE_END) begin
      if (enc_ne < ENTRY_LIMIT) enc_ne++;
      if (enc_ne - 1 > (1 << enc_cw) - 1 && enc_cw < WIDTH_MAX) enc_cw++;
    end
  endtask

  task automatic flush_bits();
    if (enc_bits > 0) pend.push_back(enc_acc[7:0]);
    enc_acc = 0;
    enc_bits = 0;
  endtask

  // feeds pending bytes with pulls mixed in; a refused byte is retried after a pull,
  // or dropped with all pending bytes once decoding has stopped or the input has ended
  task automatic drain(bit mark_last);
    logic took;
    bit blocked;
    blocked = 1'b0;
    while (pend.size() > 0) begin
      if (blocked || $urandom % 4 == 0) begin
        pull_once();
        blocked = 1'b0;
      end else begin
        send_item(MODE_FEED, pend[0], mark_last && pend.size() == 1, took);
        if (took) void'(pend.pop_front());
        else if (fin != ST_RUNNING || ended) pend.delete();
        else blocked = 1'b1;
      end
    end
  endtask

  task automatic catch_up();
    while ((crem > 0 || bcnt >= cw) && fin == ST_RUNNING) pull_once();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_length(int value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[16:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    olen = value[16:0];
  endtask

  function automatic int random_code();
    int r;
    r = $urandom % 100;
    if (r < 3) return CODE_RESET;
    if (r < 8 && enc_ne < (1 << enc_cw)) return $urandom_range(enc_ne, (1 << enc_cw) - 1);
    if (r < 45 || enc_ne <= FIRST_ENTRY) return $urandom_range(0, 255);
    if (r < 70) return $urandom_range(FIRST_ENTRY, enc_ne - 1);
    return enc_ne - 1 - ($urandom % ((enc_ne - FIRST_ENTRY) < 8 ? (enc_ne - FIRST_ENTRY) : 8));
  endfunction

  task automatic test_directed();
    write_length(0);
    write_length(65536);
    calm = 1'b1;
    push_code(8'h00);
    push_code(8'hFF);
    push_code(FIRST_ENTRY);
    push_code(enc_ne - 1);    // newest entry, copies its own start
    push_code(9'h1FF);        // not yet defined
    push_code(CODE_RESET);
    push_code(8'hA5);
    push_code(FIRST_ENTRY);
    drain(1'b0);
    catch_up();
    pull_once();              // short of bits: waits
    calm = 1'b0;
  endtask

  task automatic test_random_stream(int goal);
    while (n_items < goal) begin
      if (n_items % 250 < 30) calm = 1'b1;
      else calm = 1'b0;
      push_code(random_code());
      drain(1'b0);
      catch_up();
    end
    calm = 1'b0;
  endtask

  task automatic test_mid_length();
    int lo;
    lo = wpos + 4000;
    if (lo > 65536) lo = 65536;
    write_length($urandom_range(lo, 65536));
  endtask

  task automatic test_stream_end();
    int kind, cap, v;
    logic took;
    kind = $urandom % 4;
    case (kind)
      0: begin
        write_length(0);
        pull_once();
      end
      1: begin
        v = wpos + $urandom_range(1, 20);
        write_length(v > 65536 ? 65536 : v);
        repeat (25) push_code($urandom_range(0, 255));
        drain(1'b0);
      end
      2: begin
        push_code(CODE_END);
        flush_bits();
        drain(1'b1);
      end
      default: begin
        flush_bits();
        drain(1'b1);
      end
    endcase
    cap = 0;
    while (fin == ST_RUNNING && cap < 400) begin
      pull_once();
      cap++;
    end
    // after the end pulls repeat the final status; feeds are refused once the input has ended
    send_item(MODE_FEED, 8'($urandom), 1'b1, took);
    repeat (12) send_item(1'($urandom), 8'($urandom), 1'($urandom), took);
  endtask

  task automatic flag(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    dec_res_t w;
    moved = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) moved = 1'b1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      if (pending_results.size() == 0) begin
        $display("unexpected result item %0h", m_axis_tdata);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (m_axis_tdata[0] !== w.acc) flag("accepted", m_axis_tdata[0], w.acc);
        if (m_axis_tdata[1] !== w.ov) flag("out_valid", m_axis_tdata[1], w.ov);
        if (m_axis_tdata[9:2] !== w.b) flag("out_byte", m_axis_tdata[9:2], w.b);
        if (m_axis_tdata[15:10] !== 6'd0) flag("pad", m_axis_tdata[15:10], 0);
        if (m_axis_tlast !== w.last) flag("out_last", m_axis_tlast, w.last);
        if (m_axis_tuser !== w.st) flag("status", m_axis_tuser, w.st);
      end
    end
  end

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      automatic int g = pick_gap();
      m_axis_tready <= (g == 0);
      rx_stall <= (g > 0) ? g - 1 : 0;
    end
    if (rst || moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bbuf = 0; bcnt = 0; cw = WIDTH_MIN; ne = FIRST_ENTRY;
    wpos = 0; csrc = 0; crem = 0; ended = 1'b0; fin = ST_RUNNING; olen = 0;
    foreach (ent_off[i]) begin
      ent_off[i] = 0;
      ent_len[i] = 0;
    end
    foreach (hist[i]) hist[i] = 8'h00;
    enc_acc = 0; enc_bits = 0; enc_cw = WIDTH_MIN; enc_ne = FIRST_ENTRY;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream(ITEM_GOAL / 2);
    test_mid_length();
    test_random_stream(ITEM_GOAL);
    test_stream_end();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lzw_vwd_pkg.sv
hw/rtl/lzw_vwd_dict.sv
hw/rtl/lzw_vwd_hist.sv
hw/rtl/lzw_variable_width_decoder_unit.sv
bench/tb_lzw_variable_width_decoder_unit.sv
